>>> hw/rtl/olist_pkg.sv
// Shared types and constants of the ordered list engine.
// No dependencies; every other file of the block uses it.
`default_nettype none

package olist_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT       = 3'd1,
    OP_REMOVE_VALUE = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_SEARCH       = 3'd4,
    OP_READ         = 3'd5,
    OP_CLEAR        = 3'd6,
    OP_IGNORE       = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DROP,
    CELL_SCAN_MATCH,
    CELL_SCAN_READ,
    CELL_SCAN_SHIFT
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/olist_if.sv
// Request and response channel interfaces of the ordered list engine.
// Depends on olist_pkg for field widths.
`default_nettype none

interface olist_in_if;
  logic                             valid;
  logic                             ready;
  logic [olist_pkg::MODE_W-1:0]     mode;
  logic [olist_pkg::VALUE_W-1:0]    value;
  logic [olist_pkg::INDEX_W-1:0]    index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface olist_out_if;
  logic                             valid;
  logic                             ready;
  logic [olist_pkg::STATUS_W-1:0]   status;
  logic [olist_pkg::POS_W-1:0]      position;
  logic [olist_pkg::VALUE_W-1:0]    read_value;
  logic [olist_pkg::LEN_W-1:0]      list_length;

  modport source (output valid, output status, output position, output read_value,
                  output list_length, input ready);
  modport sink   (input valid, input status, input position, input read_value,
                  input list_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/olist_cell.sv
// One cell of the list chain: holds one entry plus one scan-chain stage.
// Depends on olist_pkg for the cell command type.
`default_nettype none

module olist_cell #(
  parameter int VW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  olist_pkg::cell_cmd_t       cmd,
  input  wire  [CW-1:0]              pos,
  input  wire  [CW-1:0]              fill,
  input  wire  [VW-1:0]              val,
  input  wire  [VW-1:0]              entry_dn,
  input  wire  [VW-1:0]              entry_up,
  input  wire                        hit_up,
  input  wire  [VW-1:0]              data_up,
  output logic [VW-1:0]              entry,
  output logic                       hit,
  output logic [VW-1:0]              data
);

  logic [VW-1:0] entry_r, entry_nxt;
  logic          hit_r, hit_nxt;
  logic [VW-1:0] data_r, data_nxt;
  logic          at_pos, above_pos, in_list;

  assign at_pos    = (pos == CW'(IDX));
  assign above_pos = (CW'(IDX) > pos);
  assign in_list   = (CW'(IDX) < fill);

  always_comb begin
    entry_nxt = entry_r;
    hit_nxt   = hit_r;
    data_nxt  = data_r;
    unique case (cmd)
      olist_pkg::CELL_HOLD: ;
      olist_pkg::CELL_WRITE: begin
        if (at_pos) entry_nxt = val;
      end
      olist_pkg::CELL_INSERT: begin
        if (at_pos) entry_nxt = val;
        else if (above_pos) entry_nxt = entry_dn;
      end
      olist_pkg::CELL_DROP: begin
        if (at_pos || above_pos) entry_nxt = entry_up;
      end
      olist_pkg::CELL_SCAN_MATCH: begin
        hit_nxt  = in_list && (entry_r == val);
        data_nxt = entry_r;
      end
      olist_pkg::CELL_SCAN_READ: begin
        hit_nxt  = at_pos;
        data_nxt = entry_r;
      end
      olist_pkg::CELL_SCAN_SHIFT: begin
        hit_nxt  = hit_up;
        data_nxt = data_up;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    data_r  <= data_nxt;
    if (!rst_n) hit_r <= 1'b0;
    else        hit_r <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;
  assign data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/ordered_list_engine.sv
// Ordered list engine top level: controller, chain of list cells, response register.
// Depends on olist_pkg, olist_if and olist_cell.
//
// Keeps an ordered list of up to CAPACITY values in a row of cells, one entry
// per cell, plus a fill level. One request is taken at a time. Append, insert,
// remove-at, clear, unused mode and any request rejected by an index or full
// check go from accept through decode and response load back to idle, where
// the response load waits for a free response register. Insert and remove
// shift every affected cell at once through its neighbor. Search and
// remove-value load a match bit into each cell's scan stage and shift that
// chain toward cell 0 one place per cycle until the first match is in cell 0
// or the scan passes the last held entry. Read at index i uses the same scan
// chain. The response register is loaded as soon as it is free, and a new
// request is taken while a response still waits. No clearing pass: entries
// past the fill level are never read.
`default_nettype none

module ordered_list_engine #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input wire          clk,
  input wire          rst_n,
  olist_in_if.sink    in_req,
  olist_out_if.source out_rsp
);

  localparam int VW = VALUE_WIDTH;
  localparam int LW = $clog2(CAPACITY + 1);            // fill level width
  localparam int CW = (LW > olist_pkg::INDEX_W) ? LW : olist_pkg::INDEX_W;

  // control state
  olist_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]      fill_r, fill_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // request registers
  olist_pkg::op_t     op_r;
  logic [VW-1:0]      val_r;
  logic [olist_pkg::INDEX_W-1:0] idx_r;

  // result and response registers
  olist_pkg::status_t res_status_r, res_status_nxt;
  logic [olist_pkg::POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic [olist_pkg::VALUE_W-1:0] res_rd_r, res_rd_nxt;
  logic [olist_pkg::LEN_W-1:0]   res_len_r, res_len_nxt;
  logic                          res_load;

  olist_pkg::status_t            out_status_r;
  logic [olist_pkg::POS_W-1:0]   out_pos_r;
  logic [olist_pkg::VALUE_W-1:0] out_rd_r;
  logic [olist_pkg::LEN_W-1:0]   out_len_r;

  logic in_fire, out_free, resp_load;

  // cell chain
  olist_pkg::cell_cmd_t cmd;
  logic [CW-1:0]        cell_pos;
  logic [VW-1:0]        entry_w [CAPACITY];
  logic                 hit_w   [CAPACITY];
  logic [VW-1:0]        data_w  [CAPACITY];

  // zero-extended views
  logic [VW+olist_pkg::VALUE_W-1:0] val_ext;
  logic [CW+olist_pkg::INDEX_W-1:0] idx_ext;
  logic [CW+LW-1:0]                 fill_ext, cnt_ext, fill_nxt_ext;
  logic [VW+olist_pkg::VALUE_W-1:0] data_ext;
  logic [CW-1:0]                    idx_x, fill_x, cnt_x, cnt_inc, fill_nxt_x;

  logic is_full, idx_above_fill, idx_in_list, scan_hit, scan_end, go_scan;

  assign in_fire   = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign resp_load = (state_r == olist_pkg::ST_RESP) && out_free;

  assign val_ext      = {{VW{1'b0}}, in_req.value};
  assign idx_ext      = {{CW{1'b0}}, idx_r};
  assign fill_ext     = {{CW{1'b0}}, fill_r};
  assign cnt_ext      = {{CW{1'b0}}, cnt_r};
  assign fill_nxt_ext = {{CW{1'b0}}, fill_nxt};
  assign data_ext     = {{olist_pkg::VALUE_W{1'b0}}, data_w[0]};
  assign idx_x        = idx_ext[CW-1:0];
  assign fill_x       = fill_ext[CW-1:0];
  assign cnt_x        = cnt_ext[CW-1:0];
  assign fill_nxt_x   = fill_nxt_ext[CW-1:0];
  assign cnt_inc      = CW'(cnt_x + 1'b1);

  assign is_full        = (fill_x >= CW'(CAPACITY));
  assign idx_above_fill = (idx_x > fill_x);
  assign idx_in_list    = (idx_x < fill_x);
  assign scan_hit       = hit_w[0];
  assign scan_end       = (cnt_inc >= fill_x);
  assign go_scan        = (op_r == olist_pkg::OP_SEARCH) ||
                          (op_r == olist_pkg::OP_REMOVE_VALUE) ||
                          ((op_r == olist_pkg::OP_READ) && idx_in_list);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olist_pkg::ST_IDLE: if (in_fire) state_nxt = olist_pkg::ST_EXEC;
      olist_pkg::ST_EXEC: state_nxt = go_scan ? olist_pkg::ST_SCAN : olist_pkg::ST_RESP;
      olist_pkg::ST_SCAN: if (scan_hit || scan_end) state_nxt = olist_pkg::ST_RESP;
      olist_pkg::ST_RESP: if (out_free) state_nxt = olist_pkg::ST_IDLE;
      default:            state_nxt = olist_pkg::ST_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    cmd            = olist_pkg::CELL_HOLD;
    cell_pos       = idx_x;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    res_load       = 1'b0;
    res_status_nxt = olist_pkg::STAT_OK;
    res_pos_nxt    = '0;
    res_rd_nxt     = '0;
    unique case (state_r)
      olist_pkg::ST_EXEC: begin
        cnt_nxt  = '0;
        res_load = !go_scan;
        unique case (op_r)
          olist_pkg::OP_APPEND: begin
            if (is_full) begin
              res_status_nxt = olist_pkg::STAT_FULL;
            end else begin
              cmd      = olist_pkg::CELL_WRITE;
              cell_pos = fill_x;
              fill_nxt = LW'(fill_r + 1'b1);
            end
          end
          olist_pkg::OP_INSERT: begin
            // index check wins over the full check
            if (idx_above_fill) begin
              res_status_nxt = olist_pkg::STAT_RANGE;
            end else if (is_full) begin
              res_status_nxt = olist_pkg::STAT_FULL;
            end else begin
              cmd      = olist_pkg::CELL_INSERT;
              fill_nxt = LW'(fill_r + 1'b1);
            end
          end
          olist_pkg::OP_REMOVE_AT: begin
            if (!idx_in_list) begin
              res_status_nxt = olist_pkg::STAT_RANGE;
            end else begin
              cmd      = olist_pkg::CELL_DROP;
              fill_nxt = LW'(fill_r - 1'b1);
            end
          end
          olist_pkg::OP_SEARCH, olist_pkg::OP_REMOVE_VALUE: begin
            cmd = olist_pkg::CELL_SCAN_MATCH;
          end
          olist_pkg::OP_READ: begin
            if (idx_in_list) cmd = olist_pkg::CELL_SCAN_READ;
            else             res_status_nxt = olist_pkg::STAT_RANGE;
          end
          olist_pkg::OP_CLEAR:  fill_nxt = '0;
          olist_pkg::OP_IGNORE: ;
          default: ;
        endcase
      end
      olist_pkg::ST_SCAN: begin
        cell_pos = cnt_x;
        if (scan_hit) begin
          res_load = 1'b1;
          if (op_r == olist_pkg::OP_READ) begin
            res_rd_nxt = data_ext[olist_pkg::VALUE_W-1:0];
          end else begin
            res_pos_nxt = cnt_x[olist_pkg::POS_W-1:0];
          end
          if (op_r == olist_pkg::OP_REMOVE_VALUE) begin
            cmd      = olist_pkg::CELL_DROP;
            fill_nxt = LW'(fill_r - 1'b1);
          end
        end else if (scan_end) begin
          res_load       = 1'b1;
          res_status_nxt = olist_pkg::STAT_NOT_FOUND;
        end else begin
          cmd     = olist_pkg::CELL_SCAN_SHIFT;
          cnt_nxt = LW'(cnt_r + 1'b1);
        end
      end
      default: ;
    endcase
    res_len_nxt = fill_nxt_x[olist_pkg::LEN_W-1:0];
  end

  assign out_valid_nxt = resp_load || (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olist_pkg::ST_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= olist_pkg::op_t'(in_req.mode);
      val_r <= val_ext[VW-1:0];
      idx_r <= in_req.index;
    end
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
      res_rd_r     <= res_rd_nxt;
      res_len_r    <= res_len_nxt;
    end
    if (resp_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_rd_r     <= res_rd_r;
      out_len_r    <= res_len_r;
    end
  end

  // chain of cells; neighbors at the ends read as zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] dn_entry, up_entry, up_data;
    logic          up_hit;
    if (i == 0) begin : g_lo
      assign dn_entry = '0;
    end else begin : g_lo
      assign dn_entry = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign up_entry = '0;
      assign up_hit   = 1'b0;
      assign up_data  = '0;
    end else begin : g_hi
      assign up_entry = entry_w[i+1];
      assign up_hit   = hit_w[i+1];
      assign up_data  = data_w[i+1];
    end
    olist_cell #(.VW(VW), .CW(CW), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .pos      (cell_pos),
      .fill     (fill_x),
      .val      (val_r),
      .entry_dn (dn_entry),
      .entry_up (up_entry),
      .hit_up   (up_hit),
      .data_up  (up_data),
      .entry    (entry_w[i]),
      .hit      (hit_w[i]),
      .data     (data_w[i])
    );
  end

  assign in_req.ready        = (state_r == olist_pkg::ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.position    = out_pos_r;
  assign out_rsp.read_value  = out_rd_r;
  assign out_rsp.list_length = out_len_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_x <= CW'(CAPACITY))
    else $error("fill level above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == olist_pkg::ST_EXEC))
    else $error("accepted request not decoded");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::ST_SCAN && fill_r != '0) |-> (cnt_r < fill_r))
    else $error("scan ran past the fill level");

  a_rsp_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == olist_pkg::ST_RESP))
    else $error("response raised outside response state");

  a_read_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olist_pkg::ST_SCAN && op_r == olist_pkg::OP_READ && scan_end) |-> scan_hit)
    else $error("read scan missed its entry");
`endif

endmodule

`default_nettype wire
